[rtl/core/itoa_pkg.sv]
// Shared types, constants and helpers for the integer to ASCII formatter.
// No dependencies; imported by every module of the block.
package itoa_pkg;

  typedef enum logic [1:0] {
    OP_HEX = 2'd0,
    OP_DEC = 2'd1,
    OP_CHR = 2'd2,
    OP_PAD = 2'd3
  } op_e;

  localparam int unsigned PAD_MAX    = 10;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
  localparam int unsigned JOB_DEPTH  = 4;
  localparam int unsigned JOB_AW     = $clog2(JOB_DEPTH);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Classified job handed from front to back.
  typedef struct packed {
    op_e         op;
    logic [31:0] val;  // hex: left-aligned; dec: magnitude; chr: byte in top
    logic        neg;  // dec only: emit a leading minus
    logic [3:0]  cnt;  // characters to emit (not used for dec)
  } job_t;

  // Upper-case hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'h0, nib};
    end
    return CH_ALPHA + {4'h0, nib} - 8'd10;
  endfunction

endpackage

[rtl/core/integer_to_ascii_formatter_unit.sv]
// Top level of the integer to ASCII formatter: front end, job queue and
// back end. Depends on itoa_pkg, itoa_front and itoa_back.
//
// Usage: requests enter through a queue-style port (push / full) as an
// insert kind op_i (hex, signed decimal, character, padding) and a 32-bit
// value_i. Characters leave through a queue-style port (empty / pop) as
// ch_o with last_o marking the final character of each request. Padding
// of zero is accepted and produces no characters.
// Flow: a hex, character or padding request passes the job queue and is
// loaded by the back end when it is free; a decimal request first runs
// through BCD conversion (four bits a cycle) and an alignment state.
// Throughput: the back end emits one character per cycle while the
// output queue has room, so a request occupies it for each of its
// characters (2 to 8 for hex, up to 10 for padding, up to 11 for
// decimal, which first passes conversion and alignment). The four-word
// job queue lets requests be accepted every cycle until it fills; full
// then follows the back end.
// Reset clears both queues and returns the back end to idle. When the
// receiver stops popping, the two-word output queue fills, emission halts
// and the job queue absorbs further requests before full rises.
module integer_to_ascii_formatter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  ch_o,
  output logic        last_o
);
  import itoa_pkg::*;

  job_t job;
  logic job_valid, job_pop;

  // Classify and queue requests.
  itoa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .value_i     (value_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // Convert and emit characters.
  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .ch_o        (ch_o),
    .last_o      (last_o)
  );

endmodule

[rtl/core/itoa_front.sv]
// Front end of the formatter: accepts requests, classifies them into jobs and
// queues them for the back end. Depends on itoa_pkg.
module itoa_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           op_i,
  input  logic [31:0]          value_i,
  output logic                 job_valid_o,
  output itoa_pkg::job_t       job_o,
  input  logic                 job_pop_i
);
  import itoa_pkg::*;

  job_t              mem_q [JOB_DEPTH];
  logic [JOB_AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [JOB_AW:0]   cnt_q, cnt_d;
  job_t              job_new;
  logic              accept, wr;
  op_e               op;
  logic [2:0]        nbytes;

  assign op     = op_e'(op_i);
  assign full   = (cnt_q == (JOB_AW+1)'(JOB_DEPTH));
  assign accept = push && !full;
  // Zero padding yields no characters: drop it here.
  assign wr     = accept && !((op == OP_PAD) && (value_i == 32'h0));

  always_comb begin
    if (value_i[31:24] != 8'h0) begin
      nbytes = 3'd4;
    end else if (value_i[23:16] != 8'h0) begin
      nbytes = 3'd3;
    end else if (value_i[15:8] != 8'h0) begin
      nbytes = 3'd2;
    end else begin
      nbytes = 3'd1;
    end
  end

  always_comb begin
    job_new.op  = op;
    job_new.neg = 1'b0;
    job_new.val = value_i;
    job_new.cnt = 4'd1;
    case (op)
      OP_HEX: begin
        job_new.val = value_i << {3'd4 - nbytes, 3'b000};
        job_new.cnt = {nbytes, 1'b0};
      end
      OP_DEC: begin
        job_new.neg = value_i[31];
        job_new.val = value_i[31] ? (~value_i + 32'd1) : value_i;
      end
      OP_CHR: begin
        job_new.val = {value_i[7:0], 24'h0};
      end
      OP_PAD: begin
        job_new.cnt = (value_i > 32'(PAD_MAX)) ? 4'(PAD_MAX) : value_i[3:0];
      end
      default: begin
        job_new.cnt = 4'd1;
      end
    endcase
  end

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (job_pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    case ({wr, job_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= job_new;
    end
  end

  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rptr_q];

endmodule

[rtl/core/itoa_back.sv]
// Formatter back end (needs itoa_pkg): converts decimal jobs to BCD, then
// emits one character per cycle into a two-word output queue if not full.
module itoa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  itoa_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     ch_o,
  output logic           last_o
);
  import itoa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_ALIGN,
    S_EMIT
  } state_e;

  state_e            state_q;
  op_e               op_q;
  logic [BCD_W-1:0]  sh_q;
  logic [31:0]       bin_q;
  logic [2:0]        step_q;
  logic [3:0]        cnt_q;
  logic              neg_q;

  logic [7:0]        och_q [2];
  logic              olast_q [2];
  logic              owptr_q, orptr_q;
  logic [1:0]        ocnt_q;

  logic              emit, ld, opop;
  logic [7:0]        ch_cur;
  logic [3:0]        nd, lz;

  // Four double-dabble steps: correct every digit, then shift in one bit.
  function automatic logic [BCD_W-1:0] dabble4(input logic [BCD_W-1:0] bcd,
                                               input logic [3:0] bits);
    logic [BCD_W-1:0] acc;
    acc = bcd;
    for (int b = 3; b >= 0; b--) begin
      for (int d = 0; d < DEC_DIGITS; d++) begin
        if (acc[4*d +: 4] >= 4'd5) begin
          acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], bits[b]};
    end
    return acc;
  endfunction

  // Significant decimal digits, at least one.
  always_comb begin
    nd = 4'd1;
    for (int d = 0; d < DEC_DIGITS; d++) begin
      if (sh_q[4*d +: 4] != 4'h0) begin
        nd = 4'(d + 1);
      end
    end
    lz = 4'(DEC_DIGITS) - nd;
  end

  always_comb begin
    case (op_q)
      OP_HEX:  ch_cur = hex_char(sh_q[BCD_W-1 -: 4]);
      OP_DEC:  ch_cur = neg_q ? CH_MINUS : hex_char(sh_q[BCD_W-1 -: 4]);
      OP_CHR:  ch_cur = sh_q[BCD_W-1 -: 8];
      OP_PAD:  ch_cur = CH_SPACE;
      default: ch_cur = CH_SPACE;
    endcase
  end

  assign emit      = (state_q == S_EMIT) && (ocnt_q != 2'd2);
  assign ld        = job_valid_i &&
                     ((state_q == S_IDLE) || (emit && (cnt_q == 4'd1)));
  assign job_pop_o = ld;
  assign opop      = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_HEX;
      sh_q    <= '0;
      bin_q   <= '0;
      step_q  <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      case (state_q)
        S_CONV: begin
          sh_q   <= dabble4(sh_q, bin_q[31:28]);
          bin_q  <= bin_q << 4;
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) begin
            state_q <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          sh_q    <= sh_q << {lz, 2'b00};
          cnt_q   <= nd + {3'b000, neg_q};
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            cnt_q <= cnt_q - 4'd1;
            if ((op_q == OP_DEC) && neg_q) begin
              neg_q <= 1'b0;
            end else begin
              sh_q <= sh_q << 4;
            end
            if ((cnt_q == 4'd1) && !ld) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // Load the next job; overrides the tail of the one just finished.
      if (ld) begin
        op_q   <= job_i.op;
        neg_q  <= job_i.neg;
        cnt_q  <= job_i.cnt;
        step_q <= '0;
        bin_q  <= job_i.val;
        if (job_i.op == OP_DEC) begin
          sh_q    <= '0;
          state_q <= S_CONV;
        end else begin
          sh_q    <= {job_i.val, 8'h00};
          state_q <= S_EMIT;
        end
      end
    end
  end

  // Output queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= 1'b0;
      orptr_q <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      if (emit) begin
        owptr_q <= ~owptr_q;
      end
      if (opop) begin
        orptr_q <= ~orptr_q;
      end
      case ({emit, opop})
        2'b10:   ocnt_q <= ocnt_q + 2'd1;
        2'b01:   ocnt_q <= ocnt_q - 2'd1;
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      och_q[owptr_q]   <= ch_cur;
      olast_q[owptr_q] <= (cnt_q == 4'd1);
    end
  end

  assign empty  = (ocnt_q == 2'd0);
  assign ch_o   = och_q[orptr_q];
  assign last_o = olast_q[orptr_q];

endmodule

[tb/sv/tb.sv]
// Self-checking bench for integer_to_ascii_formatter_unit: directed and random
// insert requests, characters predicted in-bench and checked in order.
// Depends on itoa_pkg (op_e) and the RTL of the formatter.
module tb;
  import itoa_pkg::*;

  // Settle time once the last character is seen; covers a zero pad in flight.
  localparam int unsigned SETTLE_CYCLES = 24;
  // Run limit, several times the slowest legal run with long stalls.
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned RANDOM_COUNT  = 136;

  typedef struct {
    op_e         op;
    logic [31:0] val;
    bit          drain;  // hold this request until every character is back
  } request_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } text_char_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        push    = 1'b0;
  logic [1:0]  op_i    = OP_HEX;
  logic [31:0] value_i = '0;
  logic        pop     = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  ch_o;
  logic        last_o;

  request_t    request_q[$];
  text_char_t  text_q[$];

  int unsigned cycle_cnt   = 0;
  int unsigned error_cnt   = 0;
  int unsigned accept_cnt  = 0;
  int unsigned char_cnt    = 0;
  int unsigned op_cnt[4]   = '{0, 0, 0, 0};
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned settle_left = 0;
  bit          settling    = 1'b0;
  bit          calm        = 1'b0;

  integer_to_ascii_formatter_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .op_i    (op_i),
    .value_i (value_i),
    .empty   (empty),
    .pop     (pop),
    .ch_o    (ch_o),
    .last_o  (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Idle length for either side: mostly none or short, now and then long.
  // Calm stretches switch idling off altogether.
  function automatic int unsigned next_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    string digits;
    digits = "0123456789ABCDEF";
    return digits[nib];
  endfunction

  // Append the characters one insert request yields to the text queue and
  // flag the final one. A zero pad appends nothing.
  function automatic void format_insert(input op_e op, input logic [31:0] val);
    text_char_t  c;
    logic [31:0] mag;
    logic [7:0]  b;
    int unsigned place;
    int unsigned q;
    int unsigned n;
    int unsigned first;
    bit          started;
    first   = text_q.size();
    started = 1'b0;
    c.fin   = 1'b0;
    case (op)
      OP_HEX: begin
        if (val == '0) begin
          c.ch = "0";
          text_q.push_back(c);
          text_q.push_back(c);
        end else begin
          // Drop leading zero bytes only; interior zero bytes still print.
          for (int pos = 3; pos >= 0; pos--) begin
            b = val[pos*8 +: 8];
            if (b != 8'h00) begin
              started = 1'b1;
            end
            if (started) begin
              c.ch = hex_digit(b[7:4]);
              text_q.push_back(c);
              c.ch = hex_digit(b[3:0]);
              text_q.push_back(c);
            end
          end
        end
      end
      OP_DEC: begin
        mag = val;
        if (val == '0) begin
          c.ch = "0";
          text_q.push_back(c);
        end else begin
          if (val[31]) begin
            c.ch = "-";
            text_q.push_back(c);
            // Unsigned negate: the most negative value stays 2147483648.
            mag = ~val + 32'd1;
          end
          place = 1000000000;
          for (int k = 0; k < 10; k++) begin
            q = mag / place;
            if (q != 0) begin
              started = 1'b1;
            end
            if (started) begin
              c.ch = hex_digit(4'(q % 10));
              text_q.push_back(c);
            end
            place = place / 10;
          end
        end
      end
      OP_CHR: begin
        c.ch = val[7:0];
        text_q.push_back(c);
      end
      default: begin
        n = (val < PAD_MAX) ? val : PAD_MAX;
        c.ch = " ";
        for (int unsigned k = 0; k < n; k++) begin
          text_q.push_back(c);
        end
      end
    endcase
    if (text_q.size() > first) begin
      text_q[text_q.size() - 1].fin = 1'b1;
    end
  endfunction

  task automatic add_request(input op_e op, input logic [31:0] val, input bit drain);
    request_t r;
    r.op    = op;
    r.val   = val;
    r.drain = drain;
    request_q.push_back(r);
  endtask

  // Cycle count, calm stretches and the run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Driver: present queued requests, predict on acceptance, idle between
  // words. A request marked drain waits for the text queue to empty and then
  // for the settle time before it goes out.
  always @(posedge clk_i) begin : driver
    logic drive;
    drive = push;
    if (!rst_ni) begin
      push    <= 1'b0;
      op_i    <= OP_HEX;
      value_i <= '0;
    end else begin
      if (push && !full) begin
        format_insert(op_e'(op_i), value_i);
        accept_cnt++;
        op_cnt[op_i]++;
        drive    = 1'b0;
        gap_left = next_gap();
      end
      if (!drive) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          if (request_q[0].drain) begin
            // Hold until every expected word is back, then let the block settle.
            if (!settling && text_q.size() == 0) begin
              settling    = 1'b1;
              settle_left = SETTLE_CYCLES;
            end else if (settling) begin
              if (settle_left > 0) begin
                settle_left--;
              end else begin
                settling           = 1'b0;
                request_q[0].drain = 1'b0;
              end
            end
          end
          if (!request_q[0].drain) begin
            drive = 1'b1;
            op_i    <= request_q[0].op;
            value_i <= request_q[0].val;
            void'(request_q.pop_front());
          end
        end
      end
      push <= drive;
    end
  end

  // Monitor: take characters with random stalls and check each against the
  // oldest expected word.
  always @(posedge clk_i) begin : monitor
    text_char_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        char_cnt++;
        if (text_q.size() == 0) begin
          $error("unexpected character: ch=%h last=%b", ch_o, last_o);
          error_cnt++;
        end else begin
          want = text_q.pop_front();
          if (ch_o !== want.ch) begin
            $error("ch mismatch: expected %h, actual %h", want.ch, ch_o);
            error_cnt++;
          end
          if (last_o !== want.fin) begin
            $error("last mismatch: expected %b, actual %b", want.fin, last_o);
            error_cnt++;
          end
        end
        stall_left = next_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] v;
    op_e         op;
    // Directed: field extremes, every kind, and the named corner cases.
    add_request(OP_HEX, 32'h0000_0000, 1'b0);
    add_request(OP_HEX, 32'h0000_000A, 1'b0);
    add_request(OP_HEX, 32'h0000_0100, 1'b0);
    add_request(OP_HEX, 32'h1200_0034, 1'b0);
    add_request(OP_HEX, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_HEX, 32'h0001_0000, 1'b0);
    add_request(OP_DEC, 32'd0, 1'b0);
    add_request(OP_DEC, 32'd1, 1'b0);
    add_request(OP_DEC, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_DEC, 32'h8000_0000, 1'b0);
    add_request(OP_DEC, 32'h7FFF_FFFF, 1'b0);
    add_request(OP_DEC, 32'd1000000000, 1'b0);
    add_request(OP_DEC, 32'd999999999, 1'b0);
    add_request(OP_DEC, -32'sd10, 1'b0);
    add_request(OP_CHR, 32'h0000_0000, 1'b0);
    add_request(OP_CHR, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_CHR, 32'hFFFF_FF41, 1'b0);
    add_request(OP_PAD, 32'd0, 1'b0);
    add_request(OP_PAD, 32'd1, 1'b0);
    add_request(OP_PAD, 32'd9, 1'b0);
    add_request(OP_PAD, 32'd10, 1'b0);
    add_request(OP_PAD, 32'd11, 1'b0);
    add_request(OP_PAD, 32'hFFFF_FFFF, 1'b0);
    add_request(OP_PAD, 32'd0, 1'b0);
    add_request(OP_DEC, 32'h8000_0000, 1'b1);
    // Random: wide operands, shortened ones for varied lengths, small and
    // small negative values; pads mostly from 0 to 12, spanning the cap.
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      op = op_e'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(0, 31);
        2: v = $urandom_range(0, 12);
        default: v = -$urandom_range(1, 100000);
      endcase
      if (op == OP_PAD && $urandom_range(0, 3) != 0) begin
        v = $urandom_range(0, 12);
      end
      add_request(op, v, (i == 60 || i == 120));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all requests out, all characters back, then settle. Sample
    // between edges so the driver's updates of the same edge are seen.
    while (request_q.size() != 0 || push) begin
      @(negedge clk_i);
    end
    while (text_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (hex %0d, dec %0d, chr %0d, pad %0d), %0d characters checked",
             accept_cnt, op_cnt[OP_HEX], op_cnt[OP_DEC], op_cnt[OP_CHR], op_cnt[OP_PAD],
             char_cnt);
    $display("mismatches: %0d, cycles: %0d", error_cnt, cycle_cnt);
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/itoa_pkg.sv
rtl/core/itoa_front.sv
rtl/core/itoa_back.sv
rtl/core/integer_to_ascii_formatter_unit.sv
tb/sv/tb.sv
